// ===== design/tsac_pkg.sv =====
// Shared types and constants of the turret sweep aim controller.
package tsac_pkg;

  localparam int CfgIdxWidth  = 3;
  localparam int CfgDataWidth = 16;

  localparam logic [CfgIdxWidth-1:0] CFG_ROT_SLOPE  = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_ROT_INTCPT = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_TGT_BAND   = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_ADJ_GAIN   = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CFG_ADJ_FEED   = 3'd4;
  localparam logic [CfgIdxWidth-1:0] CFG_ADJ_MAX    = 3'd5;
  localparam logic [CfgIdxWidth-1:0] CFG_TRAVEL_LIM = 3'd6;
  localparam logic [CfgIdxWidth-1:0] CFG_ON_MARGIN  = 3'd7;

  // 0.4 in Q0.15
  localparam logic [14:0] BANG_DRIVE = 15'd13107;
  localparam logic signed [15:0] OFFSET_LIMIT = 16'sd32767;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OFF_MUL,
    ST_OFF_FIN,
    ST_SWEEP,
    ST_CM1,
    ST_CM2,
    ST_DINIT,
    ST_DIV,
    ST_CFIN,
    ST_SETP,
    ST_MAG,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic load;
    logic off_mul;
    logic off_fin;
    logic sweep;
    logic cm1;
    logic cm2;
    logic div_init;
    logic div_step;
    logic cfin;
    logic setp;
    logic mag;
    logic fin;
  } ctrl_t;

  typedef struct packed {
    logic do_center;
    logic den_zero;
    logic div_last;
    logic out_busy;
  } status_t;

endpackage

// ===== design/tsac_ctrl.sv =====
// Sequencer of the turret sweep aim controller.
module tsac_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  tsac_pkg::status_t status_i,
  output tsac_pkg::ctrl_t   ctrl_o,
  output logic              in_ready_o
);

  tsac_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsac_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tsac_pkg::ST_IDLE:    if (in_valid_i) state_d = tsac_pkg::ST_OFF_MUL;
      tsac_pkg::ST_OFF_MUL: state_d = tsac_pkg::ST_OFF_FIN;
      tsac_pkg::ST_OFF_FIN: state_d = tsac_pkg::ST_SWEEP;
      tsac_pkg::ST_SWEEP: begin
        state_d = status_i.do_center ? tsac_pkg::ST_CM1 : tsac_pkg::ST_SETP;
      end
      tsac_pkg::ST_CM1:     state_d = tsac_pkg::ST_CM2;
      tsac_pkg::ST_CM2:     state_d = tsac_pkg::ST_DINIT;
      tsac_pkg::ST_DINIT: begin
        state_d = status_i.den_zero ? tsac_pkg::ST_SETP : tsac_pkg::ST_DIV;
      end
      tsac_pkg::ST_DIV:     if (status_i.div_last) state_d = tsac_pkg::ST_CFIN;
      tsac_pkg::ST_CFIN:    state_d = tsac_pkg::ST_SETP;
      tsac_pkg::ST_SETP:    state_d = tsac_pkg::ST_MAG;
      tsac_pkg::ST_MAG:     state_d = tsac_pkg::ST_FIN;
      tsac_pkg::ST_FIN:     if (!status_i.out_busy) state_d = tsac_pkg::ST_IDLE;
      default:              state_d = tsac_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o          = '0;
    in_ready_o      = 1'b0;
    case (state_q)
      tsac_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        ctrl_o.load  = in_valid_i;
      end
      tsac_pkg::ST_OFF_MUL: ctrl_o.off_mul  = 1'b1;
      tsac_pkg::ST_OFF_FIN: ctrl_o.off_fin  = 1'b1;
      tsac_pkg::ST_SWEEP:   ctrl_o.sweep    = 1'b1;
      tsac_pkg::ST_CM1:     ctrl_o.cm1      = 1'b1;
      tsac_pkg::ST_CM2:     ctrl_o.cm2      = 1'b1;
      tsac_pkg::ST_DINIT:   ctrl_o.div_init = 1'b1;
      tsac_pkg::ST_DIV:     ctrl_o.div_step = 1'b1;
      tsac_pkg::ST_CFIN:    ctrl_o.cfin     = 1'b1;
      tsac_pkg::ST_SETP:    ctrl_o.setp     = 1'b1;
      tsac_pkg::ST_MAG:     ctrl_o.mag      = 1'b1;
      tsac_pkg::ST_FIN:     ctrl_o.fin      = !status_i.out_busy;
      default: ;
    endcase
  end

endmodule

// ===== design/tsac_datapath.sv =====
// Datapath: config registers, offset, sweep tracking, center divider, drive.
module tsac_datapath #(
  parameter int ROTATE_SCALE_Q8 = 128,
  parameter int ENCODER_WIDTH   = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  tsac_pkg::ctrl_t                      ctrl_i,
  output tsac_pkg::status_t                    status_o,
  input  logic                                 cfg_we_i,
  input  logic [tsac_pkg::CfgIdxWidth-1:0]     cfg_addr_i,
  input  logic [tsac_pkg::CfgDataWidth-1:0]    cfg_wdata_i,
  input  logic                                 cmd_i,
  input  logic                                 vis_i,
  input  logic [9:0]                           cx_i,
  input  logic [11:0]                          dist_i,
  input  logic                                 mov_i,
  input  logic signed [ENCODER_WIDTH-1:0]      enc_i,
  input  logic [1:0]                           dir_i,
  input  logic signed [ENCODER_WIDTH-1:0]      tgt_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic                                 drive_valid_o,
  output logic signed [15:0]                   motor_drive_o,
  output logic                                 on_target_o,
  output logic                                 center_found_o
);

  localparam int EW = ENCODER_WIDTH;
  localparam int NW = EW + 18;
  localparam int CW = $clog2(NW);
  localparam int XW = ((EW > 16) ? EW : 16) + 2;
  localparam logic [8:0] SCALE = 9'(ROTATE_SCALE_Q8);
  localparam logic signed [NW:0] CHI = (NW+1)'((64'sd1 <<< (EW - 1)) - 64'sd1);
  localparam logic signed [NW:0] CLO = -CHI - (NW+1)'(1);

  // configuration
  logic signed [15:0] slope_q;
  logic signed [11:0] intcpt_q;
  logic [9:0]  band_q;
  logic [15:0] gain_q;
  logic [14:0] feed_q, amax_q, tlim_q, margin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slope_q  <= '0;
      intcpt_q <= '0;
      band_q   <= '0;
      gain_q   <= '0;
      feed_q   <= '0;
      amax_q   <= 15'h7fff;
      tlim_q   <= 15'h7fff;
      margin_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        tsac_pkg::CFG_ROT_SLOPE:  slope_q  <= cfg_wdata_i;
        tsac_pkg::CFG_ROT_INTCPT: intcpt_q <= cfg_wdata_i[11:0];
        tsac_pkg::CFG_TGT_BAND:   band_q   <= cfg_wdata_i[9:0];
        tsac_pkg::CFG_ADJ_GAIN:   gain_q   <= cfg_wdata_i;
        tsac_pkg::CFG_ADJ_FEED:   feed_q   <= cfg_wdata_i[14:0];
        tsac_pkg::CFG_ADJ_MAX:    amax_q   <= cfg_wdata_i[14:0];
        tsac_pkg::CFG_TRAVEL_LIM: tlim_q   <= cfg_wdata_i[14:0];
        tsac_pkg::CFG_ON_MARGIN:  margin_q <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  // input word
  logic cmd_q, vis_q, mov_q;
  logic [9:0] cx_q;
  logic [11:0] dist_q;
  logic signed [EW-1:0] enc_q, tgt_q;
  logic [1:0] dir_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q  <= cmd_i;
      vis_q  <= vis_i;
      cx_q   <= cx_i;
      dist_q <= dist_i;
      mov_q  <= mov_i;
      enc_q  <= enc_i;
      dir_q  <= dir_i;
      tgt_q  <= tgt_i;
    end
  end

  logic aim;
  logic dir_pos, dir_neg;
  assign aim     = !cmd_q && vis_q;
  assign dir_pos = (dir_q == 2'b01);
  assign dir_neg = dir_q[1];

  // aim offset
  logic signed [28:0] p_q;
  logic signed [29:0] p_r;
  logic signed [21:0] lin;
  logic signed [22:0] off_w;
  logic signed [15:0] off_q, off_sat;

  assign p_r   = {p_q[28], p_q} + 30'sd128;
  assign lin   = p_r[29:8];
  assign off_w = {lin[21], lin} + {{11{intcpt_q[11]}}, intcpt_q} - $signed({13'd0, cx_q});

  always_comb begin
    if (cx_q == 10'd0) begin
      off_sat = '0;
    end else if (off_w > 23'sd32767) begin
      off_sat = tsac_pkg::OFFSET_LIMIT;
    end else if (off_w < -23'sd32767) begin
      off_sat = -tsac_pkg::OFFSET_LIMIT;
    end else begin
      off_sat = off_w[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.off_mul) p_q <= slope_q * $signed({1'b0, dist_q});
    if (ctrl_i.off_fin) off_q <= off_sat;
  end

  // sweep tracking
  logic started_right_q, right_seen_q, left_seen_q, center_valid_q;
  logic signed [EW-1:0] maxr_cnt_q, minl_cnt_q, center_cnt_q, setpoint_q;
  logic signed [15:0] maxr_off_q, minl_off_q;

  assign status_o.do_center = aim && !mov_q &&
      (started_right_q ? (dir_neg && right_seen_q) : (dir_pos && left_seen_q));

  // center divider signals
  logic [15:0] wl;
  logic signed [17:0] den;
  logic signed [EW+16:0] m1, prod_a_q;
  logic signed [EW+15:0] m2;
  logic signed [NW-1:0] num_q;
  logic [NW-1:0] dvd_q;
  logic [16:0] dsr_q, rem_q;
  logic [17:0] rem_sh, rem_sub;
  logic ge;
  logic [CW-1:0] cnt_q;
  logic qneg_q;
  logic signed [NW:0] sq;

  assign wl      = minl_off_q[15] ? -minl_off_q : minl_off_q;
  assign den     = {{2{maxr_off_q[15]}}, maxr_off_q} + $signed({2'b00, wl});
  assign m1      = maxr_cnt_q * $signed({1'b0, wl});
  assign m2      = minl_cnt_q * maxr_off_q;
  assign rem_sh  = {rem_q, dvd_q[NW-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_q};
  assign ge      = (rem_sh >= {1'b0, dsr_q});
  assign sq      = qneg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});

  assign status_o.den_zero = (den == 18'sd0);
  assign status_o.div_last = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cm1) prod_a_q <= m1;
    if (ctrl_i.cm2) num_q <= NW'(prod_a_q) + NW'(m2);
    if (ctrl_i.div_init) begin
      dvd_q  <= num_q[NW-1] ? -num_q : num_q;
      dsr_q  <= den[17] ? 17'(-den) : den[16:0];
      rem_q  <= '0;
      cnt_q  <= CW'(NW - 1);
      qneg_q <= num_q[NW-1] ^ den[17];
    end else if (ctrl_i.div_step) begin
      rem_q <= ge ? rem_sub[16:0] : rem_sh[16:0];
      dvd_q <= {dvd_q[NW-2:0], ge};
      cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_right_q <= 1'b1;
      right_seen_q    <= 1'b0;
      left_seen_q     <= 1'b0;
      center_valid_q  <= 1'b0;
      maxr_cnt_q      <= '0;
      minl_cnt_q      <= '0;
      maxr_off_q      <= '0;
      minl_off_q      <= '0;
      center_cnt_q    <= '0;
      setpoint_q      <= '0;
    end else begin
      if (ctrl_i.sweep && aim) begin
        if (mov_q) begin
          started_right_q <= (off_q > 16'sd0);
          right_seen_q    <= 1'b0;
          left_seen_q     <= 1'b0;
          center_valid_q  <= 1'b0;
          maxr_cnt_q      <= '0;
          minl_cnt_q      <= '0;
          maxr_off_q      <= '0;
          minl_off_q      <= '0;
        end else begin
          // the side opposite the one the sweep started on is taken on every still tick
          if (started_right_q || dir_neg) begin
            if (!left_seen_q || enc_q < minl_cnt_q) minl_cnt_q <= enc_q;
            if (!left_seen_q || off_q < minl_off_q) minl_off_q <= off_q;
            left_seen_q <= 1'b1;
          end else if (dir_pos && left_seen_q && off_q < minl_off_q) begin
            minl_off_q <= off_q;
          end
          if (!started_right_q || dir_pos) begin
            if (!right_seen_q || enc_q > maxr_cnt_q) maxr_cnt_q <= enc_q;
            if (!right_seen_q || off_q > maxr_off_q) maxr_off_q <= off_q;
            right_seen_q <= 1'b1;
          end else if (dir_neg && right_seen_q && off_q > maxr_off_q) begin
            maxr_off_q <= off_q;
          end
        end
      end
      if (ctrl_i.cfin) begin
        center_valid_q <= 1'b1;
        if (sq > CHI) begin
          center_cnt_q <= CHI[EW-1:0];
        end else if (sq < CLO) begin
          center_cnt_q <= CLO[EW-1:0];
        end else begin
          center_cnt_q <= sq[EW-1:0];
        end
      end
      if (ctrl_i.setp) begin
        if (cmd_q) begin
          setpoint_q <= tgt_q;
        end else if (vis_q && center_valid_q) begin
          setpoint_q <= center_cnt_q;
        end
      end
    end
  end

  // drive
  logic [15:0] abs_off;
  logic [30:0] pprod_q;
  logic [26:0] pm;
  logic [14:0] mag_q, mag_d;
  logic neg_q, neg_d;
  logic signed [XW-1:0] enc_x, sp_x, marg_x, tlim_x;
  logic signed [16:0] off_x, band_x;

  assign abs_off = off_q[15] ? -off_q : off_q;
  assign pm      = 27'(pprod_q[30:5]) + 27'(feed_q);
  assign enc_x   = XW'(enc_q);
  assign sp_x    = XW'(setpoint_q);
  assign marg_x  = $signed(XW'(margin_q));
  assign tlim_x  = $signed(XW'(tlim_q));
  assign off_x   = 17'(off_q);
  assign band_x  = $signed({7'd0, band_q});

  always_comb begin
    mag_d = '0;
    neg_d = 1'b0;
    if (!cmd_q) begin
      if (!vis_q || center_valid_q) begin
        if (sp_x > enc_x + marg_x) begin
          mag_d = tsac_pkg::BANG_DRIVE;
          neg_d = 1'b1;
        end else if (sp_x < enc_x - marg_x) begin
          mag_d = tsac_pkg::BANG_DRIVE;
        end
      end else begin
        if (off_x > band_x || off_x < -band_x) begin
          mag_d = (pm > 27'(amax_q)) ? amax_q : pm[14:0];
          neg_d = !(off_x > band_x);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sweep) pprod_q <= abs_off[14:0] * gain_q;
    if (ctrl_i.mag) begin
      mag_q <= mag_d;
      neg_q <= neg_d;
    end
  end

  logic [23:0] sc;
  logic [14:0] s15;
  logic stop;
  logic signed [15:0] drive;

  assign sc    = 24'(mag_q) * 24'(SCALE);
  assign s15   = sc[22:8];
  assign stop  = (s15 != 15'd0) &&
                 ((!neg_q && enc_x < -tlim_x) || (neg_q && enc_x > tlim_x));
  assign drive = stop ? 16'sd0 : (neg_q ? -$signed({1'b0, s15}) : $signed({1'b0, s15}));

  logic out_valid_q;
  assign status_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.fin) begin
      drive_valid_o  <= !cmd_q;
      motor_drive_o  <= drive;
      on_target_o    <= (enc_x >= sp_x - marg_x) && (enc_x <= sp_x + marg_x);
      center_found_o <= center_valid_q;
    end
  end

endmodule

// ===== design/turret_sweep_aim_controller_unit.sv =====
// Top level of the turret sweep aim controller.
// One input word is one control tick or a setpoint load; it yields one output word
// with the turret drive, on-target flag and center flag. Each word steps through the
// offset, sweep, setpoint, magnitude and finish states; the next word is accepted
// once the result has left the finish state. A tick that closes a sweep also forms
// the weighted center with the bit-per-cycle restoring divider; if the center
// weights sum to zero the divider is skipped. One word is worked on at a time;
// a finished result waits in the output register until taken.
module turret_sweep_aim_controller_unit #(
  parameter int ROTATE_SCALE_Q8 = 128,
  parameter int ENCODER_WIDTH   = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tsac_pkg::CfgIdxWidth-1:0]  cfg_addr_i,
  input  logic [tsac_pkg::CfgDataWidth-1:0] cfg_wdata_i,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // vision_active, center_x, target_distance, robot_moving, encoder_count,
  // turn_direction, target_position
  input  logic [((26 + 2 * ENCODER_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // command
  input  logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // motor_drive, on_target, center_found
  output logic [23:0] m_axis_tdata,
  // drive_valid
  output logic m_axis_tuser
);

  localparam int EW    = ENCODER_WIDTH;
  localparam int P_ENC = 24;
  localparam int P_DIR = P_ENC + EW;
  localparam int P_TGT = P_DIR + 2;

  tsac_pkg::ctrl_t   ctrl;
  tsac_pkg::status_t status;
  logic signed [15:0] drive;
  logic on_tgt, cfound;

  tsac_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .status_i   (status),
    .ctrl_o     (ctrl),
    .in_ready_o (s_axis_tready)
  );

  tsac_datapath #(
    .ROTATE_SCALE_Q8 (ROTATE_SCALE_Q8),
    .ENCODER_WIDTH   (ENCODER_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (s_axis_tuser),
    .vis_i          (s_axis_tdata[0]),
    .cx_i           (s_axis_tdata[10:1]),
    .dist_i         (s_axis_tdata[22:11]),
    .mov_i          (s_axis_tdata[23]),
    .enc_i          (s_axis_tdata[P_DIR-1:P_ENC]),
    .dir_i          (s_axis_tdata[P_TGT-1:P_DIR]),
    .tgt_i          (s_axis_tdata[P_TGT+EW-1:P_TGT]),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .drive_valid_o  (m_axis_tuser),
    .motor_drive_o  (drive),
    .on_target_o    (on_tgt),
    .center_found_o (cfound)
  );

  assign m_axis_tdata = {6'd0, cfound, on_tgt, drive};

endmodule
